### design/sdrhe_pkg.sv
package sdrhe_pkg;

  localparam int DataW         = 32;
  localparam int StepsPerStage = 4;
  localparam int DivStages     = DataW / StepsPerStage;

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] den;
    logic             neg;
    logic             zero;
  } div_stage_t;

  function automatic div_stage_t div_steps(input div_stage_t s);
    div_stage_t     r;
    logic [DataW:0] part;
    logic [DataW:0] diff;
    r = s;
    for (int i = 0; i < StepsPerStage; i++) begin
      part = {r.rem, r.acc[DataW-1]};
      diff = part - {1'b0, r.den};
      if (part >= {1'b0, r.den}) begin
        r.rem = diff[DataW-1:0];
        r.acc = {r.acc[DataW-2:0], 1'b1};
      end else begin
        r.rem = part[DataW-1:0];
        r.acc = {r.acc[DataW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### design/signed_divide_round_half_even.sv
// Signed divide with round half to even.
// Input channel s_axis: tdata carries the signed dividend in bits [31:0] and the
// unsigned divisor in bits [63:32]. Output channel m_axis: tdata carries the
// signed quotient, the magnitude of the dividend divided by the divisor, rounded
// to nearest with exact halves going to the even value, then given the sign of
// the dividend. A zero divisor returns zero.
// From acceptance to tvalid on the output, an item passes through eleven
// register stages: one holds the magnitude, eight each retire four quotient bits
// of a restoring divider, one rounds and one output stage restores the sign.
// Throughput: one item per cycle; every stage holds one item with its own valid bit.
// Reset clears all valid bits, so the pipe comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_axis_tready drops; no item is lost or repeated. While the output register is
// empty or being taken, the pipe advances and a new item is taken each cycle.
module signed_divide_round_half_even
  import sdrhe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*DataW-1:0]   s_axis_tdata_i,   // dividend [31:0], divisor [63:32]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DataW-1:0]     m_axis_tdata_o    // quotient [31:0]
);

  logic              advance;
  logic [DataW-1:0]  dividend;
  logic [DataW-1:0]  divisor;
  div_stage_t        load;

  div_stage_t        stage_q [DivStages+1];
  logic              valid_q [DivStages+1];

  logic [DataW-1:0]  rq_d;
  logic [DataW-1:0]  rq_q;
  logic              rneg_q;
  logic              rzero_q;
  logic              rvalid_q;
  logic [DataW:0]    twice_rem;
  logic              round_up;

  logic [DataW-1:0]  out_d;
  logic [DataW-1:0]  out_q;
  logic              out_neg_q;
  logic              out_valid_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign dividend        = s_axis_tdata_i[DataW-1:0];
  assign divisor         = s_axis_tdata_i[2*DataW-1:DataW];

  always_comb begin
    load.rem  = '0;
    load.den  = divisor;
    load.neg  = dividend[DataW-1];
    load.zero = (divisor == '0);
    load.acc  = dividend[DataW-1] ? (DataW'(0) - dividend) : dividend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivStages; k++) valid_q[k] <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k <= DivStages; k++) valid_q[k] <= valid_q[k-1];
      rvalid_q    <= valid_q[DivStages];
      out_valid_q <= rvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage_q[0] <= load;
      for (int k = 1; k <= DivStages; k++) stage_q[k] <= div_steps(stage_q[k-1]);
    end
  end

  assign twice_rem = {stage_q[DivStages].rem, 1'b0};
  assign round_up  = (twice_rem > {1'b0, stage_q[DivStages].den}) ||
                     ((twice_rem == {1'b0, stage_q[DivStages].den}) &&
                      stage_q[DivStages].acc[0]);
  assign rq_d      = stage_q[DivStages].acc + DataW'(round_up);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rq_q    <= rq_d;
      rneg_q  <= stage_q[DivStages].neg;
      rzero_q <= stage_q[DivStages].zero;
    end
  end

  always_comb begin
    if (rzero_q) begin
      out_d = '0;
    end else if (rneg_q) begin
      out_d = DataW'(0) - rq_q;
    end else begin
      out_d = rq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q     <= out_d;
      out_neg_q <= rneg_q && !rzero_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> valid_q[0])
    else $error("accepted item did not enter the pipe");

  a_result_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DataW-1] == (out_neg_q && (out_q != '0))))
    else $error("quotient sign does not follow the dividend");
`endif

endmodule

### test/signed_divide_round_half_even_tb.sv
`timescale 1ns / 100ps

module signed_divide_round_half_even_tb;
  import sdrhe_pkg::*;

  localparam int RandItems = 1500;
  localparam int DirRowCnt = 21;
  localparam int IdleLimit = 2000;
  localparam int DrainWait = 20;

  typedef struct packed {
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
    logic             known;
    logic [DataW-1:0] quotient;
  } div_row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [2*DataW-1:0] s_axis_tdata_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [DataW-1:0]   m_axis_tdata_o;

  logic [DataW-1:0] quotient_q[$];
  int               err_cnt     = 0;
  int               burst_left  = 1;
  int               idle_cycles = 0;
  int               stall_mode  = 0;
  int               stall_left  = 0;
  div_row_t         dir_rows[DirRowCnt];

  signed_divide_round_half_even u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DataW-1:0] rounded_quotient(input logic [DataW-1:0] dvd,
                                                        input logic [DataW-1:0] dvs);
    logic             neg;
    logic [DataW-1:0] mag;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
    logic [DataW:0]   twice_rem;
    if (dvs == '0) begin
      return '0;
    end
    neg       = dvd[DataW-1];
    mag       = neg ? -dvd : dvd;
    quo       = mag / dvs;
    rem       = mag % dvs;
    twice_rem = {rem, 1'b0};
    if (twice_rem > {1'b0, dvs} || (twice_rem == {1'b0, dvs} && quo[0])) begin
      quo = quo + 1'b1;
    end
    return neg ? -quo : quo;
  endfunction

  function automatic int next_burst();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
  endfunction

  task automatic offer_item(input logic [DataW-1:0] dvd, input logic [DataW-1:0] dvs,
                            input bit known, input logic [DataW-1:0] quot,
                            input bit is_last);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {dvs, dvd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    quotient_q.push_back(known ? quot : rounded_quotient(dvd, dvs));
    burst_left--;
    if (is_last || burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      if (!is_last) begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = next_burst();
      end
    end
  endtask

  // receiver: always ready, coin flip, or mostly stalled, in phases
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (quotient_q.size() == 0) begin
        $display("%0t: quotient %h with none expected", $time, m_axis_tdata_o);
        err_cnt++;
      end else begin
        if (m_axis_tdata_o !== quotient_q[0]) begin
          $display("%0t: quotient mismatch, expected %h, got %h",
                   $time, quotient_q[0], m_axis_tdata_o);
          err_cnt++;
        end
        void'(quotient_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("signed_divide_round_half_even_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [DataW-1:0] dvd;
    logic [DataW-1:0] dvs;
    logic [DataW-1:0] mag;
    logic [DataW-1:0] quo;
    dir_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{32'h0000_0005, 32'h0000_0002, 1'b1, 32'h0000_0002},
      '{32'h0000_0007, 32'h0000_0002, 1'b1, 32'h0000_0004},
      '{32'hFFFF_FFFB, 32'h0000_0002, 1'b1, 32'hFFFF_FFFE},
      '{32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFC},
      '{32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF, 32'h0000_0003, 1'b1, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0002, 1'b1, 32'hC000_0000},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF},
      '{32'h4000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
      '{32'h0000_000E, 32'h0000_0004, 1'b0, 32'h0000_0000},
      '{32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0000_0000}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = next_burst();

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].dividend, dir_rows[i].divisor, dir_rows[i].known,
                 dir_rows[i].quotient, 1'b0);
    end

    for (int n = 0; n < RandItems; n++) begin
      dvd = $urandom;
      dvs = $urandom;
      case ($urandom_range(0, 9))
        0: dvs = '0;
        1: begin
          // land on, just above or just below the halfway point
          dvs = $urandom_range(1, 16'hFFFF);
          quo = $urandom_range(0, 16'h3FFF);
          mag = quo * dvs + (dvs >> 1) + $urandom_range(0, 1);
          dvd = $urandom_range(0, 1) ? -mag : mag;
        end
        2: dvs = $urandom_range(1, 16);
        3: dvs = dvs | 32'h8000_0000;
        4: begin
          case ($urandom_range(0, 4))
            0: dvd = 32'h8000_0000;
            1: dvd = 32'h7FFF_FFFF;
            2: dvd = 32'h0000_0000;
            3: dvd = 32'h0000_0001;
            default: dvd = 32'hFFFF_FFFF;
          endcase
          if ($urandom_range(0, 1)) begin
            dvs = $urandom_range(0, 4);
          end
        end
        5: begin
          // exact half against a divisor of at least 2^31
          mag = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
          dvs = {mag[DataW-2:0], 1'b0};
          dvd = $urandom_range(0, 1) ? -mag : mag;
        end
        default: ;
      endcase
      offer_item(dvd, dvs, 1'b0, '0, n == RandItems - 1);
    end

    while (quotient_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("signed_divide_round_half_even_tb: done, clean");
    end else begin
      $display("signed_divide_round_half_even_tb: done, errors");
    end
    $finish;
  end

endmodule
